/* design/cmhc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmhc_pkg
// Shared types, constants and tables for the calibrated compass heading block.
// ----------------------------------------------------------------------------
package cmhc_pkg;

    localparam int DATA_W           = 16;
    localparam int FRAC_SHIFT       = 12;
    localparam int DIV_BITS         = DATA_W + FRAC_SHIFT;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int X_W              = 28;
    localparam int ANG_W            = 21;
    localparam int PI_Q16           = 205887;
    localparam int TWO_PI_Q13       = 51472;
    localparam int SB_W             = 3 * DATA_W + 1;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_X     = 3'd0;
    localparam logic [2:0] REG_MAX_X     = 3'd1;
    localparam logic [2:0] REG_MIN_Y     = 3'd2;
    localparam logic [2:0] REG_MAX_Y     = 3'd3;
    localparam logic [2:0] REG_MIN_Z     = 3'd4;
    localparam logic [2:0] REG_MAX_Z     = 3'd5;
    localparam logic [2:0] REG_DECL      = 3'd6;
    localparam logic [2:0] REG_AXIS_MODE = 3'd7;

    // vertical axis codes
    localparam logic [2:0] MODE_POS_X = 3'd0;
    localparam logic [2:0] MODE_NEG_X = 3'd1;
    localparam logic [2:0] MODE_POS_Y = 3'd2;
    localparam logic [2:0] MODE_NEG_Y = 3'd3;
    localparam logic [2:0] MODE_POS_Z = 3'd4;
    localparam logic [2:0] MODE_NEG_Z = 3'd5;
    localparam logic [2:0] MODE_NONE  = 3'd6;

    typedef struct packed {
        logic [DATA_W-1:0] half;
        logic              neg;
        logic              num_zero;
        logic              div_zero;
    } cmhc_div_ctl_t;

    // atan(2^-i) in Q.16 radians, rounded
    function automatic logic [16:0] atan_q16(input int unsigned i);
        logic [16:0] v;
        case (i)
            0:       v = 17'd51472;
            1:       v = 17'd30386;
            2:       v = 17'd16055;
            3:       v = 17'd8150;
            4:       v = 17'd4091;
            5:       v = 17'd2047;
            6:       v = 17'd1024;
            7:       v = 17'd512;
            8:       v = 17'd256;
            9:       v = 17'd128;
            10:      v = 17'd64;
            11:      v = 17'd32;
            12:      v = 17'd16;
            13:      v = 17'd8;
            14:      v = 17'd4;
            15:      v = 17'd2;
            16:      v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* design/compass_heading_calibrated.sv */
// A result passes the lane registers, the CORDIC stages and the output register.
// Throughput: one beat per cycle unless the skid entry is full; the three axis
// divide lanes (one quotient bit per stage) and CORDIC stages are fully pipelined.
// A two-entry output stage keeps input open while one result waits.
// Reset (aresetn low, synchronous) clears pipeline valids and the output stage,
// and loads min_* = 32767, max_* = -32768, declination 0, axis mode +z.
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_calibrated
// Hard-iron calibrated three-axis magnetometer heading: per-axis lanes, axis
// selection, CORDIC atan2 and declination with wrap into 0..2pi.
// ----------------------------------------------------------------------------
module compass_heading_calibrated #(
    parameter int CORDIC_STEPS = cmhc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // scaled_x, scaled_y, scaled_z, heading_angle
    output logic             m_tuser,   // divide_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import cmhc_pkg::*;

    localparam logic signed [ANG_W-1:0] TWO_PI_H = ANG_W'(TWO_PI_Q13);

    logic signed [DATA_W-1:0] min_reg [0:2];
    logic signed [DATA_W-1:0] max_reg [0:2];
    logic signed [DATA_W-1:0] decl_reg;
    logic [2:0]               mode_reg;

    logic                     pipe_en;
    logic                     lane_v [0:2];
    logic signed [DATA_W-1:0] lane_s [0:2];
    logic                     lane_e [0:2];

    logic signed [DATA_W-1:0] sel1;
    logic signed [DATA_W-1:0] sel2;
    logic                     sel_neg;
    logic signed [DATA_W:0]   a1;
    logic signed [DATA_W:0]   a2;

    logic                     cor_v;
    logic signed [ANG_W-1:0]  cor_ang;
    logic [SB_W-1:0]          sb_reg [0:CORDIC_STEPS];

    logic signed [ANG_W-1:0]  ang_q13;
    logic signed [ANG_W-1:0]  h_sum;
    logic signed [ANG_W-1:0]  h_wrap;
    logic [64:0]              res;

    logic        m_valid_reg;
    logic [64:0] m_reg;
    logic        skid_valid_reg;
    logic [64:0] skid_reg;
    logic        out_take;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                min_reg[k] <= 16'sh7FFF;
                max_reg[k] <= 16'sh8000;
            end
            decl_reg <= '0;
            mode_reg <= MODE_POS_Z;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_X:     min_reg[0] <= cfg_data;
                REG_MAX_X:     max_reg[0] <= cfg_data;
                REG_MIN_Y:     min_reg[1] <= cfg_data;
                REG_MAX_Y:     max_reg[1] <= cfg_data;
                REG_MIN_Z:     min_reg[2] <= cfg_data;
                REG_MAX_Z:     max_reg[2] <= cfg_data;
                REG_DECL:      decl_reg   <= cfg_data;
                REG_AXIS_MODE: mode_reg   <= cfg_data[2:0];
                default:       mode_reg   <= mode_reg;
            endcase
        end
    end

    // whole pipeline moves unless the skid entry is occupied
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        cmhc_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (s_tvalid),
            .raw       (s_tdata[DATA_W*k +: DATA_W]),
            .lo        (min_reg[k]),
            .hi        (max_reg[k]),
            .out_valid (lane_v[k]),
            .scaled    (lane_s[k]),
            .div_err   (lane_e[k])
        );
    end

    // horizontal pair from the vertical-axis mode
    always_comb begin
        case (mode_reg)
            MODE_POS_X, MODE_NEG_X: begin
                sel1 = lane_s[1];
                sel2 = lane_s[2];
            end
            MODE_POS_Y, MODE_NEG_Y: begin
                sel1 = lane_s[0];
                sel2 = lane_s[2];
            end
            MODE_POS_Z, MODE_NEG_Z: begin
                sel1 = lane_s[0];
                sel2 = lane_s[1];
            end
            default: begin
                sel1 = '0;
                sel2 = '0;
            end
        endcase
        sel_neg = (mode_reg == MODE_NEG_X) || (mode_reg == MODE_NEG_Y)
               || (mode_reg == MODE_NEG_Z);
        a1 = sel_neg ? -{sel1[DATA_W-1], sel1} : {sel1[DATA_W-1], sel1};
        a2 = sel_neg ? -{sel2[DATA_W-1], sel2} : {sel2[DATA_W-1], sel2};
    end

    cmhc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (lane_v[0]),
        .a1        (a1),
        .a2        (a2),
        .out_valid (cor_v),
        .ang       (cor_ang)
    );

    // scaled values and error ride alongside the CORDIC
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sb_reg[0] <= {lane_e[0] | lane_e[1] | lane_e[2], lane_s[2], lane_s[1], lane_s[0]};
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                sb_reg[k+1] <= sb_reg[k];
            end
        end
    end

    // Q.16 to Q3.13 with rounding, add declination, wrap into 0..2pi
    always_comb begin
        ang_q13 = (cor_ang + ANG_W'(4)) >>> 3;
        h_sum   = ang_q13 + {{(ANG_W-DATA_W){decl_reg[DATA_W-1]}}, decl_reg};
        if (h_sum < 0) begin
            h_wrap = (h_sum + TWO_PI_H < 0) ? h_sum + TWO_PI_H + TWO_PI_H : h_sum + TWO_PI_H;
        end else if (h_sum > TWO_PI_H) begin
            h_wrap = h_sum - TWO_PI_H;
        end else begin
            h_wrap = h_sum;
        end
        res = {sb_reg[CORDIC_STEPS][SB_W-1], h_wrap[DATA_W-1:0],
               sb_reg[CORDIC_STEPS][3*DATA_W-1:0]};
    end

    // output register plus skid entry
    assign out_take = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (cor_v) begin
            if (m_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                m_reg <= skid_reg;
            end
        end else if (cor_v) begin
            if (m_valid_reg && !m_tready) begin
                skid_reg <= res;
            end else begin
                m_reg <= res;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_reg[63:0];
    assign m_tuser  = m_reg[64];

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without an output beat");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_reg[63:48] <= 16'd51472))
        else $error("heading outside 0..2pi");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pipe_en && cor_v) |=> (cor_v && $stable(sb_reg[CORDIC_STEPS])))
        else $error("pipeline moved while the skid entry was full");

endmodule
`default_nettype wire

/* design/cmhc_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmhc_lane
// One axis lane: hard-iron offset removal and pipelined restoring divide by
// the half range, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module cmhc_lane (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [cmhc_pkg::DATA_W-1:0] raw,
    input  wire logic signed [cmhc_pkg::DATA_W-1:0] lo,
    input  wire logic signed [cmhc_pkg::DATA_W-1:0] hi,
    output logic                                out_valid,
    output logic signed [cmhc_pkg::DATA_W-1:0]  scaled,
    output logic                                div_err
);
    import cmhc_pkg::*;

    logic signed [DATA_W:0]   sum_c;
    logic signed [DATA_W:0]   centre;
    logic signed [DATA_W+1:0] diff;
    logic [DATA_W:0]          abs_lo;
    logic [DATA_W:0]          abs_hi;
    logic [DATA_W:0]          sum_h;
    logic [DATA_W+1:0]        mag_w;

    logic                v_reg   [0:DIV_BITS+1];
    logic [DATA_W-1:0]   r_reg   [0:DIV_BITS];
    logic [DIV_BITS-1:0] w_reg   [0:DIV_BITS];
    cmhc_div_ctl_t       ctl_reg [0:DIV_BITS];
    logic signed [DATA_W-1:0] scaled_reg;
    logic                     err_reg;
    logic signed [DATA_W-1:0] scaled_next;

    always_comb begin
        sum_c  = {lo[DATA_W-1], lo} + {hi[DATA_W-1], hi};
        // halve toward zero
        centre = $signed(sum_c + {{DATA_W{1'b0}}, sum_c[DATA_W]}) >>> 1;
        diff   = {{2{raw[DATA_W-1]}}, raw} - {centre[DATA_W], centre};
        abs_lo = lo[DATA_W-1] ? -{lo[DATA_W-1], lo} : {1'b0, lo};
        abs_hi = hi[DATA_W-1] ? -{hi[DATA_W-1], hi} : {1'b0, hi};
        sum_h  = abs_lo + abs_hi;
        mag_w  = diff[DATA_W+1] ? -diff : diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_BITS + 1; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k <= DIV_BITS; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]            <= '0;
            w_reg[0]            <= {mag_w[DATA_W-1:0], {FRAC_SHIFT{1'b0}}};
            ctl_reg[0].half     <= sum_h[DATA_W:1];
            ctl_reg[0].neg      <= diff[DATA_W+1];
            ctl_reg[0].num_zero <= (diff == '0);
            ctl_reg[0].div_zero <= (sum_h[DATA_W:1] == '0);
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        logic [DATA_W-1:0] trial;
        logic              take;
        always_comb begin
            trial = {r_reg[k][DATA_W-2:0], w_reg[k][DIV_BITS-1]};
            take  = (trial >= ctl_reg[k].half);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]   <= take ? trial - ctl_reg[k].half : trial;
                w_reg[k+1]   <= {w_reg[k][DIV_BITS-2:0], take};
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    always_comb begin
        if (ctl_reg[DIV_BITS].div_zero) begin
            if (ctl_reg[DIV_BITS].neg) begin
                scaled_next = 16'sh8000;
            end else if (ctl_reg[DIV_BITS].num_zero) begin
                scaled_next = '0;
            end else begin
                scaled_next = 16'sh7FFF;
            end
        end else if (ctl_reg[DIV_BITS].neg) begin
            if (w_reg[DIV_BITS] > DIV_BITS'(32768)) begin
                scaled_next = 16'sh8000;
            end else begin
                scaled_next = DATA_W'(-w_reg[DIV_BITS]);
            end
        end else begin
            if (w_reg[DIV_BITS] > DIV_BITS'(32767)) begin
                scaled_next = 16'sh7FFF;
            end else begin
                scaled_next = w_reg[DIV_BITS][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scaled_reg <= scaled_next;
            err_reg    <= ctl_reg[DIV_BITS].div_zero;
        end
    end

    assign out_valid = v_reg[DIV_BITS+1];
    assign scaled    = scaled_reg;
    assign div_err   = err_reg;

endmodule
`default_nettype wire

/* design/cmhc_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmhc_cordic
// Pipelined vectoring CORDIC atan2: half-plane pre-rotation, then one
// micro-rotation per stage. Angle out in Q.16 radians.
// ----------------------------------------------------------------------------
module cmhc_cordic #(
    parameter int STEPS = cmhc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [cmhc_pkg::DATA_W:0]  a1,
    input  wire logic signed [cmhc_pkg::DATA_W:0]  a2,
    output logic                                   out_valid,
    output logic signed [cmhc_pkg::ANG_W-1:0]      ang
);
    import cmhc_pkg::*;

    logic signed [X_W-1:0]   ax;
    logic signed [X_W-1:0]   ay;
    logic                    v_reg [0:STEPS];
    logic                    z_reg [0:STEPS];
    logic signed [X_W-1:0]   x_reg [0:STEPS];
    logic signed [X_W-1:0]   y_reg [0:STEPS];
    logic signed [ANG_W-1:0] a_reg [0:STEPS];

    always_comb begin
        ax = {{(X_W-DATA_W-9){a1[DATA_W]}}, a1, 8'b0};
        ay = {{(X_W-DATA_W-9){a2[DATA_W]}}, a2, 8'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < STEPS; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // left half plane folds over by pi
    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0] <= (a1 == '0) && (a2 == '0);
            if (ax < 0) begin
                x_reg[0] <= -ax;
                y_reg[0] <= -ay;
                a_reg[0] <= (ay >= 0) ? ANG_W'(PI_Q16) : -ANG_W'(PI_Q16);
            end else begin
                x_reg[0] <= ax;
                y_reg[0] <= ay;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [X_W-1:0]   xs;
        logic signed [X_W-1:0]   ys;
        logic signed [ANG_W-1:0] step;
        always_comb begin
            xs   = x_reg[i] >>> i;
            ys   = y_reg[i] >>> i;
            step = ANG_W'(atan_q16(i));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                z_reg[i+1] <= z_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    a_reg[i+1] <= a_reg[i] + step;
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    a_reg[i+1] <= a_reg[i] - step;
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign ang       = z_reg[STEPS] ? '0 : a_reg[STEPS];

endmodule
`default_nettype wire

/* bench/compass_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compass_checker
// Watches the sample, result and register channels of the compass heading
// block, predicts each result from the raw sample and the register values,
// and compares results in order.
// ----------------------------------------------------------------------------
module compass_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    import cmhc_pkg::*;

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
        logic [15:0] heading;
        logic        derr;
    } heading_t;

    logic signed [15:0] cal_min [3];
    logic signed [15:0] cal_max [3];
    logic signed [15:0] decl;
    logic [2:0]         mode;
    heading_t           expected_q[$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] scale_axis(logic signed [15:0] raw,
            logic signed [15:0] lo, logic signed [15:0] hi, inout logic err);
        longint centre, half, num, q, alo, ahi;
        centre = (longint'(hi) + longint'(lo)) / 2;
        alo = lo < 0 ? -longint'(lo) : longint'(lo);
        ahi = hi < 0 ? -longint'(hi) : longint'(hi);
        half = (ahi + alo) / 2;
        num = (longint'(raw) - centre) * 4096;
        if (half == 0) begin
            err = 1'b1;
            q = num > 0 ? 32767 : (num < 0 ? -32768 : 0);
        end else begin
            q = num / half;
        end
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic longint atan2_q16(longint b, longint a);
        longint x, y, ang, t, xs, ys;
        x = a * 256;
        y = b * 256;
        ang = 0;
        if (a == 0 && b == 0) return 0;
        if (x < 0) begin
            ang = (y >= 0) ? PI_Q16 : -PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y >= 0) begin
                t = x + ys; y = y - xs; x = t; ang += atan_q16(i);
            end else begin
                t = x - ys; y = y + xs; x = t; ang -= atan_q16(i);
            end
        end
        return ang;
    endfunction

    function automatic heading_t predict_heading(logic [47:0] d);
        heading_t r;
        logic signed [15:0] s [3];
        longint a1, a2, h;
        logic err;
        err = 1'b0;
        a1 = 0;
        a2 = 0;
        for (int k = 0; k < 3; k++)
            s[k] = scale_axis(d[16*k +: 16], cal_min[k], cal_max[k], err);
        case (mode)
            MODE_POS_X, MODE_NEG_X: begin a1 = s[1]; a2 = s[2]; end
            MODE_POS_Y, MODE_NEG_Y: begin a1 = s[0]; a2 = s[2]; end
            MODE_POS_Z, MODE_NEG_Z: begin a1 = s[0]; a2 = s[1]; end
            default: ;
        endcase
        if (mode == MODE_NEG_X || mode == MODE_NEG_Y || mode == MODE_NEG_Z) begin
            a1 = -a1;
            a2 = -a2;
        end
        h = floor_sh(atan2_q16(a2, a1) + 4, 3) + longint'(decl);
        while (h < 0) h += TWO_PI_Q13;
        while (h > TWO_PI_Q13) h -= TWO_PI_Q13;
        r.sx = s[0];
        r.sy = s[1];
        r.sz = s[2];
        r.heading = h[15:0];
        r.derr = err;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        heading_t e;
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                cal_min[k] <= 16'sh7FFF;
                cal_max[k] <= 16'sh8000;
            end
            decl <= '0;
            mode <= MODE_POS_Z;
            fail_count <= 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_X: cal_min[0] <= cfg_data;
                    REG_MAX_X: cal_max[0] <= cfg_data;
                    REG_MIN_Y: cal_min[1] <= cfg_data;
                    REG_MAX_Y: cal_max[1] <= cfg_data;
                    REG_MIN_Z: cal_min[2] <= cfg_data;
                    REG_MAX_Z: cal_max[2] <= cfg_data;
                    REG_DECL:  decl <= cfg_data;
                    REG_AXIS_MODE: mode <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_heading(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[15:0] !== e.sx || m_tdata[31:16] !== e.sy ||
                        m_tdata[47:32] !== e.sz || m_tdata[63:48] !== e.heading ||
                        m_tuser !== e.derr)
                        fail_count <= fail_count + 1;
                    if (m_tdata[15:0] !== e.sx)
                        $error("scaled_x expected %h got %h", e.sx, m_tdata[15:0]);
                    if (m_tdata[31:16] !== e.sy)
                        $error("scaled_y expected %h got %h", e.sy, m_tdata[31:16]);
                    if (m_tdata[47:32] !== e.sz)
                        $error("scaled_z expected %h got %h", e.sz, m_tdata[47:32]);
                    if (m_tdata[63:48] !== e.heading)
                        $error("heading_angle expected %0d got %0d", e.heading,
                               m_tdata[63:48]);
                    if (m_tuser !== e.derr)
                        $error("divide_error expected %b got %b", e.derr, m_tuser);
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the calibrated compass heading block: register phases across
// calibration bounds, declinations and axis modes, directed corner samples and
// random bursts, with random output stalls. Checking is in compass_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import cmhc_pkg::*;

    localparam int DRAIN_CYCLES = CORDIC_STEPS_DEF + 40;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    longint      cycles = 0;
    int          stall_mode = 0;

    always #2 aclk = ~aclk;

    compass_heading_calibrated uut (.*);
    compass_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stall pattern, changes style now and then
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 3) != 0;
            2: m_tready <= $urandom_range(0, 1);
            default: m_tready <= $urandom_range(0, 7) == 0;
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // drive one sample; valid stays high when the next beat follows directly
    task automatic send_sample(logic [47:0] d, bit keep);
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (!keep) s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(int n);
        int gap;
        int left;
        left = n;
        while (left > 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--) begin
                send_sample({rand_raw(), rand_raw(), rand_raw()},
                            left > 1 && (b > 1 || gap == 0));
                left--;
            end
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic random_config();
        logic [15:0] lo, hi;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 4))
                0: begin lo = 16'h8000; hi = 16'h7FFF; end
                1: begin lo = 16'($urandom); hi = -lo; end  // zero centre
                2: begin lo = 16'($urandom_range(0, 3)); hi = -lo; end // tiny range
                default: begin lo = -16'($urandom_range(1, 20000));
                               hi = 16'($urandom_range(1, 20000)); end
            endcase
            write_reg(3'(2 * k), lo);
            write_reg(3'(2 * k + 1), hi);
        end
        case ($urandom_range(0, 3))
            0: write_reg(REG_DECL, 16'd25736);
            1: write_reg(REG_DECL, -16'sd25736);
            default: write_reg(REG_DECL, 16'($signed(16'($urandom_range(0, 51472)))
                                               - 16'sd25736));
        endcase
        write_reg(REG_AXIS_MODE, 16'($urandom_range(0, 7)));
    endtask

    initial begin
        logic [15:0] corner [6];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset bounds give a half range of 32767 on every axis
        for (int i = 0; i < 6; i++)
            send_sample({corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6]}, i < 5);
        wait_idle();

        // full-range x and y calibration, half-range z, every axis mode, extreme declinations
        write_reg(REG_MIN_X, 16'h8000); write_reg(REG_MAX_X, 16'h7FFF);
        write_reg(REG_MIN_Y, 16'h8000); write_reg(REG_MAX_Y, 16'h7FFF);
        write_reg(REG_MIN_Z, 16'hC000); write_reg(REG_MAX_Z, 16'h4000);
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_AXIS_MODE, 16'(m));
            write_reg(REG_DECL, m[0] ? 16'd25736 : -16'sd25736);
            send_sample({16'h0000, 16'h0000, 16'h0000}, 1'b1); // zero pair
            send_sample({16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0);
            wait_idle();
        end

        for (int phase = 0; phase < 12; phase++) begin
            random_config();
            random_burst(150);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
